### rtl/b64se_pkg.sv
`default_nettype none

package b64se_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [5:0] SIXBIT_MASK = 6'h3F;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // The characters that one byte produces, with the index of the final one.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_index;
      logic            end_of_message;
   } bundle_type;

   typedef struct packed {
      logic       push;
      bundle_type bundle;
   } queue_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] encode_sextet(input logic [5:0] value);
      logic [7:0] v;
      v = {2'b00, value & SIXBIT_MASK};
      if (v < 8'd26) begin
         encode_sextet = 8'h41 + v;
      end else if (v < 8'd52) begin
         encode_sextet = 8'h61 + (v - 8'd26);
      end else if (v < 8'd62) begin
         encode_sextet = 8'h30 + (v - 8'd52);
      end else if (v == 8'd62) begin
         encode_sextet = 8'h2B;
      end else begin
         encode_sextet = 8'h2F;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/b64se_channels.sv
`default_nettype none

interface b64se_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64se_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

### rtl/b64se_front.sv
`default_nettype none

module b64se_front (
   input  wire                          clock,
   input  wire                          reset,
   b64se_req_if.sink                    req,
   input  wire b64se_pkg::queue_status_type status,
   output b64se_pkg::queue_wr_type      wr
);
   import b64se_pkg::*;

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [3:0]  leftover_ff;
   logic [3:0]  leftover_in;
   logic        accept;
   logic [7:0]  b;
   bundle_type  bundle;

   assign req.ready = !status.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;

   always_comb begin
      bundle                = '0;
      bundle.end_of_message = req.end_of_message;
      phase_in              = PHASE_FIRST;
      leftover_in           = 4'd0;
      case (phase_ff)
         PHASE_SECOND: begin
            bundle.chars[0] = encode_sextet({leftover_ff[1:0], b[7:4]});
            if (req.end_of_message) begin
               bundle.chars[1]   = encode_sextet({b[3:0], 2'b00});
               bundle.chars[2]   = PAD_CHAR;
               bundle.last_index = 2'd2;
            end else begin
               bundle.last_index = 2'd0;
               leftover_in       = b[3:0];
               phase_in          = PHASE_THIRD;
            end
         end
         PHASE_THIRD: begin
            bundle.chars[0]   = encode_sextet({leftover_ff, b[7:6]});
            bundle.chars[1]   = encode_sextet(b[5:0]);
            bundle.last_index = 2'd1;
         end
         default: begin
            bundle.chars[0] = encode_sextet(b[7:2]);
            if (req.end_of_message) begin
               bundle.chars[1]   = encode_sextet({b[1:0], 4'b0000});
               bundle.chars[2]   = PAD_CHAR;
               bundle.chars[3]   = PAD_CHAR;
               bundle.last_index = 2'd3;
            end else begin
               bundle.last_index = 2'd0;
               leftover_in       = {2'b00, b[1:0]};
               phase_in          = PHASE_SECOND;
            end
         end
      endcase
   end

   assign wr.push   = accept;
   assign wr.bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         leftover_ff <= 4'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

`default_nettype wire

### rtl/b64se_queue.sv
`default_nettype none

module b64se_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire b64se_pkg::queue_wr_type wr,
   input  wire                          pop,
   output b64se_pkg::bundle_type        head,
   output b64se_pkg::queue_status_type  status
);
   import b64se_pkg::*;

   bundle_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = wr.push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = p + 1'b1;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/b64se_back.sv
`default_nettype none

module b64se_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire b64se_pkg::bundle_type   head,
   input  wire b64se_pkg::queue_status_type status,
   output logic                         pop,
   b64se_rsp_if.source                  rsp
);
   import b64se_pkg::*;

   logic [1:0] index_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       final_char;

   assign load       = (!valid_ff || rsp.ready) && !status.empty;
   assign final_char = (index_ff == head.last_index);
   assign pop        = load && final_char;

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.out_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            index_ff <= final_char ? 2'd0 : index_ff + 2'd1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head.chars[index_ff];
         last_ff <= final_char && head.end_of_message;
      end
   end

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// The request channel carries one message byte per word, with end_of_message
// set on the last byte of a message. The response channel carries one ASCII
// character per word, with out_last set on the final character of a message.
// A byte produces one or two characters, and the last byte of a message may
// also produce the tail character and the padding, up to four characters.
// A byte accepted at a clock edge is written to a two-entry queue at that
// edge; its characters are then loaded from the queue head into the response
// register one per cycle while the response channel takes them.
// The response channel moves one character per cycle while ready is high, so
// the sustained rate is set by the output serializer, which emits four
// characters for every three bytes in a long message.
// The request side keeps accepting while the queue has room, so a stall on
// the response side holds the current character stable and backs up into
// the queue before it stops the request side.
// Synchronous reset clears the byte phase, empties the queue and drops the
// response valid; no character is shown in the cycle after reset.
`default_nettype none

module base64_stream_encoder (
   input  wire          clock,
   input  wire          reset,
   b64se_req_if.sink    req_chan,
   b64se_rsp_if.source  rsp_chan
);
   import b64se_pkg::*;

   queue_wr_type      wr;
   queue_status_type  status;
   bundle_type        head;
   logic              pop;

   b64se_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .status (status),
      .wr     (wr)
   );

   b64se_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   b64se_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp    (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/b64se_checker.sv
`default_nettype none

module b64se_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_char,
   input wire       rsp_out_last
);

   // The response valid is low in the cycle that follows a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled character and its last flag hold until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_out_last))
      else $error("stalled response changed");

   // Every character is from the alphabet or is the pad.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_char >= 8'h41 && rsp_out_char <= 8'h5A) ||
                     (rsp_out_char >= 8'h61 && rsp_out_char <= 8'h7A) ||
                     (rsp_out_char >= 8'h30 && rsp_out_char <= 8'h39) ||
                     rsp_out_char == 8'h2B || rsp_out_char == 8'h2F ||
                     rsp_out_char == 8'h3D))
      else $error("illegal output character");

   // A pad that does not end the message is followed directly by the final pad.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_char == 8'h3D && !rsp_out_last
      |=> rsp_valid && rsp_out_char == 8'h3D && rsp_out_last)
      else $error("pad sequence broken");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_char (rsp_chan.out_char),
   .rsp_out_last (rsp_chan.out_last)
);

`default_nettype wire
